// ----- design/ple_pkg.sv -----
// ple_pkg: shared types and codes for the positional list engine
// holds command, status and cell operation codes; no dependencies
`default_nettype none

package ple_pkg;

    // command codes carried on i_command
    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_DUMP      = 3'd6,
        CMD_COUNT     = 3'd7
    } t_cmd;

    // status codes carried on o_status
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } t_cell_mode;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 6;

endpackage

`default_nettype wire

// ----- design/ple_cell.sv -----
// ple_cell: one storage cell of the list chain
// depends on ple_pkg for the cell operation codes
`default_nettype none

module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX_W = 5,
    parameter int IDX   = 0
) (
    input  wire              i_clk,
    input  t_cell_mode       i_mode,
    input  wire [IDX_W-1:0]  i_sel,
    input  wire [DATA_W-1:0] i_value,
    input  wire [DATA_W-1:0] i_left,
    input  wire [DATA_W-1:0] i_right,
    input  wire [DATA_W-1:0] i_head,
    output logic [DATA_W-1:0] o_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // pick the next entry from own, neighbor, new value or head
    always_comb begin
        n_data = r_data;
        case (i_mode)
            CELL_INS: begin
                if (MY_IDX > i_sel) begin
                    n_data = i_left;
                end else if (MY_IDX == i_sel) begin
                    n_data = i_value;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= i_sel) begin
                    n_data = i_right;
                end
            end
            CELL_ROT: begin
                if (MY_IDX == i_sel) begin
                    n_data = i_head;
                end else if (MY_IDX < i_sel) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ----- design/positional_list_engine_top.sv -----
// positional_list_engine_top: command decode, dump sequencer and the cell chain
// depends on ple_pkg and ple_cell
`default_nettype none

// Bounded ordered list of signed 32-bit values held in a chain of CAPACITY
// cells driven by one shared operation. A command is taken when start is
// high and busy is low. Inserts, deletes and count give one result on the
// cycle after the transfer. A dump of n entries (n > 0) holds busy while it
// streams one entry per cycle, front first, by rotating the occupied part of
// the chain through the head cell; an empty dump gives one result. Results
// are shown on o_strobe for a single cycle and cannot be held off, so the
// receiver must take every strobed result. After reset the list is empty and
// no clearing pass is needed.

module positional_list_engine_top
    import ple_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      start,
    input  wire  [2:0]               i_command,
    input  wire  signed [31:0]       i_value,
    input  wire  [5:0]               i_position,
    output logic                     busy,
    output logic                     o_strobe,
    output logic [1:0]               o_status,
    output logic [5:0]               o_element_count,
    output logic signed [31:0]       o_element,
    output logic                     o_element_valid,
    output logic                     o_last
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int XW    = ((CW > COUNT_W) ? CW : COUNT_W) + 1;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_occ;
    logic [CW-1:0]     r_rem;

    logic              accept;
    t_cmd              cmd;
    logic [XW-1:0]     occ_x;
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     n_occ_x;
    logic [CW-1:0]     n_occ;
    t_status           n_status;
    t_cell_mode        cell_mode;
    logic [IDX_W-1:0]  cell_sel;
    logic              is_full;
    logic              is_empty;

    logic [DATA_W-1:0] cell_q [CAPACITY];

    assign accept   = start & ~busy;
    assign busy     = (r_state == S_DUMP);
    assign cmd      = t_cmd'(i_command);
    assign occ_x    = XW'(r_occ);
    assign pos_x    = XW'(i_position);
    assign is_full  = (occ_x >= XW'(CAPACITY));
    assign is_empty = (r_occ == '0);
    assign n_occ_x  = XW'(n_occ);

    // decode the command into a status, a new count and a chain operation
    always_comb begin
        n_status  = ST_OK;
        n_occ     = r_occ;
        cell_mode = CELL_HOLD;
        cell_sel  = '0;
        if (r_state == S_DUMP) begin
            cell_mode = CELL_ROT;
            cell_sel  = IDX_W'(occ_x - XW'(1));
        end else begin
            case (cmd)
                CMD_INS_FRONT, CMD_INS_BACK: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        cell_mode = CELL_INS;
                        cell_sel  = (cmd == CMD_INS_FRONT) ? '0 : IDX_W'(occ_x);
                        n_occ     = CW'(occ_x + XW'(1));
                    end
                end
                CMD_INS_AT: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else if (pos_x == '0 || pos_x > occ_x + XW'(1)) begin
                        n_status = ST_BADPOS;
                    end else begin
                        cell_mode = CELL_INS;
                        cell_sel  = IDX_W'(pos_x - XW'(1));
                        n_occ     = CW'(occ_x + XW'(1));
                    end
                end
                CMD_DEL_FRONT, CMD_DEL_BACK: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        cell_mode = CELL_DEL;
                        cell_sel  = (cmd == CMD_DEL_FRONT) ? '0
                                                           : IDX_W'(occ_x - XW'(1));
                        n_occ     = CW'(occ_x - XW'(1));
                    end
                end
                CMD_DEL_AT: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else if (pos_x == '0 || pos_x > occ_x) begin
                        n_status = ST_BADPOS;
                    end else begin
                        cell_mode = CELL_DEL;
                        cell_sel  = IDX_W'(pos_x - XW'(1));
                        n_occ     = CW'(occ_x - XW'(1));
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
            if (!accept) begin
                cell_mode = CELL_HOLD;
            end
        end
    end

    // chain of cells, index 0 is the front
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        if (g == 0) begin : g_first
            assign left_d = i_value;
        end else begin : g_mid_l
            assign left_d = cell_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign right_d = cell_q[g];
        end else begin : g_mid_r
            assign right_d = cell_q[g+1];
        end
        ple_cell #(
            .IDX_W (IDX_W),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_mode  (cell_mode),
            .i_sel   (cell_sel),
            .i_value (i_value),
            .i_left  (left_d),
            .i_right (right_d),
            .i_head  (cell_q[0]),
            .o_data  (cell_q[g])
        );
    end

    // control state and registered result outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_occ           <= '0;
            r_rem           <= '0;
            o_strobe        <= 1'b0;
            o_status        <= ST_OK;
            o_element_count <= '0;
            o_element       <= '0;
            o_element_valid <= 1'b0;
            o_last          <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    o_strobe <= 1'b0;
                    if (accept) begin
                        if (cmd == CMD_DUMP && !is_empty) begin
                            r_state <= S_DUMP;
                            r_rem   <= r_occ;
                        end else begin
                            o_strobe        <= 1'b1;
                            o_status        <= n_status;
                            o_element_count <= n_occ_x[COUNT_W-1:0];
                            o_element       <= '0;
                            o_element_valid <= 1'b0;
                            o_last          <= 1'b1;
                            r_occ           <= n_occ;
                        end
                    end
                end
                S_DUMP: begin
                    // one entry per transfer from the head while the chain rotates
                    o_strobe        <= 1'b1;
                    o_status        <= ST_OK;
                    o_element_count <= occ_x[COUNT_W-1:0];
                    o_element       <= cell_q[0];
                    o_element_valid <= 1'b1;
                    o_last          <= (r_rem == CW'(1));
                    r_rem           <= r_rem - CW'(1);
                    if (r_rem == CW'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
